// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the following cycle, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/itl_pkg.sv
// Shared types and constants of the interval table lookup.
package itl_pkg;

	localparam int TABLE_DEPTH   = 256;
	localparam int IDX_W         = $clog2(TABLE_DEPTH);
	localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_INDEX_W = 8;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] local_first;
		logic [31:0] local_last;
	} entry_t;

	typedef struct packed {
		logic        hit;
		logic        below;
		logic [31:0] span_start;
		logic [32:0] span_size;
	} probe_t;

endpackage

// File: rtl/itl_probe.sv
// Compares a query position against the span of one table entry.
module itl_probe
	import itl_pkg::*;
(
	input  entry_t      entry,
	input  logic [31:0] query,
	output probe_t      res
);

	logic [31:0] span_lo;
	logic [31:0] span_hi;

	// both sums wrap; a wrapped entry with lo > hi never hits
	assign span_lo = entry.base + entry.local_first;
	assign span_hi = entry.base + entry.local_last;

	always_comb begin
		res.hit        = (query >= span_lo) && (query <= span_hi);
		res.below      = query < span_lo;
		res.span_start = span_lo;
		res.span_size  = {1'b0, entry.local_last - entry.local_first} + 33'd1;
	end

endmodule

// File: rtl/interval_table_lookup.sv
// Top level: entry table in a synchronous RAM with a binary search sequencer.
//
//  channel   signals                                         handshake
//  command   start, op, base_position, local_first,          start && !busy
//            local_last, query_position
//  result    done, found, span_start, span_size,             done (one cycle)
//            local_offset, entry_index
//
// Clear, append and the unused op give no result.
// A lookup makes P table probes before the done strobe, P being the number
// of table probes (0 on an empty table, at most clog2(depth)+1, so 9
// for 256 entries); one probe per cycle is set by the RAM read loop.
// busy is high while a search runs; results cannot be stalled by the receiver.
// arst_n clears the entry count and sequencer; the RAM contents are not reset.
module interval_table_lookup
	import itl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               op,
	input  logic [31:0]              base_position,
	input  logic [31:0]              local_first,
	input  logic [31:0]              local_last,
	input  logic [31:0]              query_position,
	output logic                     done,
	output logic                     found,
	output logic [31:0]              span_start,
	output logic [32:0]              span_size,
	output logic [31:0]              local_offset,
	output logic [ENTRY_INDEX_W-1:0] entry_index
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_CMP  = 2'b10
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   lo_q;
	logic [CNT_W-1:0]   hi_q;
	logic [IDX_W-1:0]   mid_q;
	logic [31:0]        query_q;
	entry_t             mem [TABLE_DEPTH];
	entry_t             rd_q;

	logic               accept;
	logic               wr_en;
	entry_t             wr_entry;
	probe_t             pr;
	logic [CNT_W-1:0]   nlo;
	logic [CNT_W-1:0]   nhi;
	logic [CNT_W:0]     nsum;
	logic [IDX_W-1:0]   rd_addr;

	assign accept   = start && !busy;
	assign busy     = (state_q == ST_CMP);
	assign wr_en    = accept && (op == OP_APPEND) && (count_q < CNT_W'(TABLE_DEPTH));
	assign wr_entry = '{base: base_position, local_first: local_first,
		local_last: local_last};

	itl_probe u_probe (
		.entry (rd_q),
		.query (query_q),
		.res   (pr)
	);

	// next search window, used while comparing
	always_comb begin
		nlo = lo_q;
		nhi = hi_q;
		if (pr.below) begin
			nhi = CNT_W'(mid_q);
		end else begin
			nlo = CNT_W'(mid_q) + CNT_W'(1);
		end
		nsum = (CNT_W + 1)'(nlo) + (CNT_W + 1)'(nhi);
		if (state_q == ST_CMP) begin
			rd_addr = IDX_W'(nsum >> 1);
		end else begin
			rd_addr = IDX_W'(count_q >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[IDX_W-1:0]] <= wr_entry;
		end
		rd_q  <= mem[rd_addr];
		mid_q <= rd_addr;
		if (accept) begin
			query_q <= query_position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							OP_CLEAR: count_q <= '0;
							OP_APPEND: begin
								if (wr_en) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							OP_LOOKUP: begin
								lo_q <= '0;
								hi_q <= count_q;
								if (count_q == '0) begin
									done <= 1'b1;
								end else begin
									state_q <= ST_CMP;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CMP: begin
					if (pr.hit) begin
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						lo_q <= nlo;
						hi_q <= nhi;
						if (nlo >= nhi) begin
							done    <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload; zeros on a miss
	always_ff @(posedge clk) begin
		if ((state_q == ST_CMP) && pr.hit) begin
			found        <= 1'b1;
			span_start   <= pr.span_start;
			span_size    <= pr.span_size;
			local_offset <= rd_q.local_first;
			entry_index  <= ENTRY_INDEX_W'(mid_q);
		end else if (!done || !found) begin
			found        <= 1'b0;
			span_start   <= '0;
			span_size    <= '0;
			local_offset <= '0;
			entry_index  <= '0;
		end else begin
			found        <= 1'b0;
			span_start   <= '0;
			span_size    <= '0;
			local_offset <= '0;
			entry_index  <= '0;
		end
	end

endmodule

// File: rtl/itl_checker.sv
// Port-level checks of the interval table lookup, bound to the top level.
`include "assert_macros.svh"

module itl_checker
	import itl_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic [1:0]               op,
	input logic [31:0]              base_position,
	input logic [31:0]              local_first,
	input logic [31:0]              local_last,
	input logic [31:0]              query_position,
	input logic                     done,
	input logic                     found,
	input logic [31:0]              span_start,
	input logic [32:0]              span_size,
	input logic [31:0]              local_offset,
	input logic [ENTRY_INDEX_W-1:0] entry_index
);

	logic lookup_acc;
	logic other_acc;
	logic miss_zero;

	assign lookup_acc = start && !busy && (op == OP_LOOKUP);
	assign other_acc  = start && !busy && (op != OP_LOOKUP);
	assign miss_zero  = (span_start == '0) && (span_size == '0) &&
		(local_offset == '0) && (entry_index == '0);

	// an accepted lookup is either answered at once or still searching
	`ASSERT_NEXT(a_lookup_progress, clk, arst_n, lookup_acc, done || busy, "lookup lost")
	// table updates give no result and never start a search
	`ASSERT_NEXT(a_update_silent, clk, arst_n, other_acc, !done && !busy, "update produced result")
	// a search ends exactly when its result appears
	`ASSERT_SAME(a_end_result, clk, arst_n, $fell(busy), done, "search ended without result")
	// a miss carries an all-zero transaction, a hit a nonzero size
	`ASSERT_SAME(a_result_fields, clk, arst_n, done, found ? (span_size != '0) : miss_zero,
		"bad result fields")

endmodule

bind interval_table_lookup itl_checker u_itl_checker (.*);
